// ----- src/qai_pkg.sv -----
package qai_pkg;

  // Fixed-point formats
  localparam int QUAT_FRAC_BITS = 30;
  localparam int RATE_FRAC_BITS = 20;
  // Step is in 1/256 ms units, rates in rad/s: delta = d * step / (1000 * 1024)
  localparam int DT_DIVISOR     = 1024000;

  // Port field widths
  localparam int DATA_W    = 32;
  localparam int STEP_W    = 16;
  localparam int CFG_IDX_W = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INIT_QW = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_INIT_QX = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_INIT_QY = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_INIT_QZ = CFG_IDX_W'(3);

  // Serial multiplier: wide parallel multiplicand, serial multiplier bits
  localparam int MA_W = 48;
  localparam int MB_W = 33;
  localparam int MP_W = MA_W + MB_W;

  // Datapath widths
  localparam int ACC_W = 66;
  localparam int ROW_W = 40;
  localparam int QN_W  = 45;
  localparam int MAG_W = 44;
  localparam int ENT_W = QUAT_FRAC_BITS + 3;

  // Serial divider and square root
  localparam int DIV_N_W    = 64;
  localparam int DIV_D_W    = 33;
  localparam int SQ_RAD_W   = 64;
  localparam int SQ_ROOT_W  = 32;
  localparam int SQ_REM_W   = SQ_ROOT_W + 4;

  // Status of a multi-cycle arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  // One product of the kinematic sums: rate index, quaternion index, sign
  typedef struct packed {
    logic [1:0] wi;
    logic [1:0] qi;
    logic       neg;
  } kin_term_t;

  // One rotation matrix entry: 2 * (q[i1]q[j1] +/- q[i2]q[j2]) - diag * 1.0
  typedef struct packed {
    logic [1:0] i1;
    logic [1:0] j1;
    logic [1:0] i2;
    logic [1:0] j2;
    logic       neg2;
    logic       diag;
  } rot_entry_t;

  function automatic kin_term_t kin_term(input logic [1:0] k, input logic [1:0] j);
    kin_term_t t;
    t = '0;
    case ({k, j})
      4'h0: t = '{wi: 2'd0, qi: 2'd1, neg: 1'b1};
      4'h1: t = '{wi: 2'd1, qi: 2'd2, neg: 1'b1};
      4'h2: t = '{wi: 2'd2, qi: 2'd3, neg: 1'b1};
      4'h4: t = '{wi: 2'd0, qi: 2'd0, neg: 1'b0};
      4'h5: t = '{wi: 2'd2, qi: 2'd2, neg: 1'b0};
      4'h6: t = '{wi: 2'd1, qi: 2'd3, neg: 1'b1};
      4'h8: t = '{wi: 2'd1, qi: 2'd0, neg: 1'b0};
      4'h9: t = '{wi: 2'd2, qi: 2'd1, neg: 1'b1};
      4'hA: t = '{wi: 2'd0, qi: 2'd3, neg: 1'b0};
      4'hC: t = '{wi: 2'd2, qi: 2'd0, neg: 1'b0};
      4'hD: t = '{wi: 2'd1, qi: 2'd1, neg: 1'b0};
      4'hE: t = '{wi: 2'd0, qi: 2'd2, neg: 1'b1};
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic rot_entry_t rot_entry(input logic [3:0] e);
    rot_entry_t r;
    r = '0;
    case (e)
      4'd0: r = '{i1: 2'd0, j1: 2'd0, i2: 2'd1, j2: 2'd1, neg2: 1'b0, diag: 1'b1};
      4'd1: r = '{i1: 2'd1, j1: 2'd2, i2: 2'd0, j2: 2'd3, neg2: 1'b1, diag: 1'b0};
      4'd2: r = '{i1: 2'd1, j1: 2'd3, i2: 2'd0, j2: 2'd2, neg2: 1'b0, diag: 1'b0};
      4'd3: r = '{i1: 2'd1, j1: 2'd2, i2: 2'd0, j2: 2'd3, neg2: 1'b0, diag: 1'b0};
      4'd4: r = '{i1: 2'd0, j1: 2'd0, i2: 2'd2, j2: 2'd2, neg2: 1'b0, diag: 1'b1};
      4'd5: r = '{i1: 2'd2, j1: 2'd3, i2: 2'd0, j2: 2'd1, neg2: 1'b1, diag: 1'b0};
      4'd6: r = '{i1: 2'd1, j1: 2'd3, i2: 2'd0, j2: 2'd2, neg2: 1'b1, diag: 1'b0};
      4'd7: r = '{i1: 2'd2, j1: 2'd3, i2: 2'd0, j2: 2'd1, neg2: 1'b0, diag: 1'b0};
      4'd8: r = '{i1: 2'd0, j1: 2'd0, i2: 2'd3, j2: 2'd3, neg2: 1'b0, diag: 1'b1};
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ----- src/qai_if.sv -----
interface qai_sample_if import qai_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] rate_x;
  logic signed [DATA_W-1:0] rate_y;
  logic signed [DATA_W-1:0] rate_z;
  logic        [STEP_W-1:0] step_time;

  modport source (output valid, rate_x, rate_y, rate_z, step_time, input ready);
  modport sink (input valid, rate_x, rate_y, rate_z, step_time, output ready);
endinterface

interface qai_result_if import qai_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] att_w;
  logic signed [DATA_W-1:0] att_x;
  logic signed [DATA_W-1:0] att_y;
  logic signed [DATA_W-1:0] att_z;
  logic signed [DATA_W-1:0] plat_rate_x;
  logic signed [DATA_W-1:0] plat_rate_y;
  logic signed [DATA_W-1:0] plat_rate_z;

  modport source (output valid, att_w, att_x, att_y, att_z,
                  plat_rate_x, plat_rate_y, plat_rate_z, input ready);
  modport sink (input valid, att_w, att_x, att_y, att_z,
                plat_rate_x, plat_rate_y, plat_rate_z, output ready);
endinterface

interface qai_cfg_if import qai_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- src/qai_mul.sv -----
module qai_mul import qai_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic signed [MA_W-1:0] a,
  input  logic signed [MB_W-1:0] b,
  output unit_stat_t             st,
  output logic signed [MP_W-1:0] p
);

  localparam int CNT_W = $clog2(MB_W);

  logic signed [MA_W:0]   hi;
  logic        [MB_W-1:0] lo;
  logic signed [MA_W-1:0] mcand;
  logic        [CNT_W-1:0] cnt;
  logic signed [MA_W:0]   sum;
  logic                   last;

  // Last multiplier bit carries negative weight
  assign last = (cnt == CNT_W'(MB_W - 1));

  always_comb begin
    sum = hi;
    if (lo[0]) begin
      sum = last ? hi - (MA_W + 1)'(mcand) : hi + (MA_W + 1)'(mcand);
    end
  end

  // One multiplier bit per cycle, shift-add with arithmetic shift right
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else begin
      st.done <= 1'b0;
      if (start) begin
        mcand   <= a;
        hi      <= '0;
        lo      <= b;
        cnt     <= '0;
        st.busy <= 1'b1;
      end else if (st.busy) begin
        hi  <= {sum[MA_W], sum[MA_W:1]};
        lo  <= {sum[0], lo[MB_W-1:1]};
        cnt <= cnt + 1'b1;
        if (last) begin
          st.busy <= 1'b0;
          st.done <= 1'b1;
        end
      end
    end
  end

  assign p = {hi[MA_W-1:0], lo};

endmodule

// ----- src/qai_div.sv -----
module qai_div import qai_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [DIV_N_W-1:0] num,
  input  logic [DIV_D_W-1:0] den,
  output unit_stat_t         st,
  output logic [DIV_N_W-1:0] quot
);

  localparam int CNT_W = $clog2(DIV_N_W);

  logic [DIV_N_W-1:0] nq;
  logic [DIV_D_W-1:0] dv;
  logic [DIV_D_W-1:0] rem;
  logic [CNT_W-1:0]   cnt;
  logic [DIV_D_W:0]   rem_sh;
  logic               ge;

  assign rem_sh = {rem, nq[DIV_N_W-1]};
  assign ge     = (rem_sh >= {1'b0, dv});

  // Restoring division, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else begin
      st.done <= 1'b0;
      if (start) begin
        nq      <= num;
        dv      <= den;
        rem     <= '0;
        cnt     <= '0;
        st.busy <= 1'b1;
      end else if (st.busy) begin
        rem <= ge ? DIV_D_W'(rem_sh - {1'b0, dv}) : DIV_D_W'(rem_sh);
        nq  <= {nq[DIV_N_W-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_N_W - 1)) begin
          st.busy <= 1'b0;
          st.done <= 1'b1;
        end
      end
    end
  end

  assign quot = nq;

endmodule

// ----- src/qai_sqrt.sv -----
module qai_sqrt import qai_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [SQ_RAD_W-1:0]  rad,
  output unit_stat_t           st,
  output logic [SQ_ROOT_W-1:0] root
);

  localparam int CNT_W = $clog2(SQ_ROOT_W);

  logic [SQ_RAD_W-1:0]  rs;
  logic [SQ_REM_W-1:0]  rem;
  logic [SQ_ROOT_W-1:0] rt;
  logic [CNT_W-1:0]     cnt;
  logic [SQ_REM_W-1:0]  rem_sh;
  logic [SQ_REM_W-1:0]  trial;
  logic                 ge;

  assign rem_sh = {rem[SQ_REM_W-3:0], rs[SQ_RAD_W-1 -: 2]};
  assign trial  = SQ_REM_W'({rt, 2'b01});
  assign ge     = (rem_sh >= trial);

  // Digit-by-digit floor square root, two radicand bits per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else begin
      st.done <= 1'b0;
      if (start) begin
        rs      <= rad;
        rem     <= '0;
        rt      <= '0;
        cnt     <= '0;
        st.busy <= 1'b1;
      end else if (st.busy) begin
        rem <= ge ? rem_sh - trial : rem_sh;
        rt  <= {rt[SQ_ROOT_W-2:0], ge};
        rs  <= {rs[SQ_RAD_W-3:0], 2'b00};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(SQ_ROOT_W - 1)) begin
          st.busy <= 1'b0;
          st.done <= 1'b1;
        end
      end
    end
  end

  assign root = rt;

endmodule

// ----- src/quaternion_attitude_integrator_top.sv -----
// Quaternion attitude integrator (two-step Adams-Bashforth on q' = q (x) w / 2).
// sample channel: one gyro sample (rate_x/y/z, Q12.20 rad/s) and step_time in
//   1/256 ms units. ready is high only while the sequencer is idle.
// result channel: normalized quaternion att_w..att_z (Q2.30) and the rate rotated
//   into the platform frame plat_rate_x..z (Q12.20, saturated), one per sample.
// cfg channel: index 0..3 writes init_qw..init_qz and loads that component into
//   both quaternion history slots; other indexes are ignored. Taken while idle.
// Run time per sample is set by the bit-serial multiplier (used 59 times), two
//   rounds of four divisions, a square root and a normalize shift loop. One
//   sample at a time.
// The result sits in an output register; the next sample is accepted while it
//   waits. If the receiver stalls, the sequencer holds its finished result in its
//   last state until the output register frees up, and accepts nothing meanwhile.
// Reset: histories hold the identity quaternion and zero rates; no clearing pass.
module quaternion_attitude_integrator_top import qai_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  qai_sample_if.sink  sample,
  qai_result_if.source result,
  qai_cfg_if.sink     cfg
);

  localparam int ST_W = 5;
  localparam logic [ST_W-1:0] S_IDLE  = 5'd0;
  localparam logic [ST_W-1:0] S_KIN   = 5'd1;
  localparam logic [ST_W-1:0] S_KINW  = 5'd2;
  localparam logic [ST_W-1:0] S_STEP  = 5'd3;
  localparam logic [ST_W-1:0] S_STEPW = 5'd4;
  localparam logic [ST_W-1:0] S_DDIV  = 5'd5;
  localparam logic [ST_W-1:0] S_DDIVW = 5'd6;
  localparam logic [ST_W-1:0] S_NSH   = 5'd7;
  localparam logic [ST_W-1:0] S_SQ    = 5'd8;
  localparam logic [ST_W-1:0] S_SQW   = 5'd9;
  localparam logic [ST_W-1:0] S_SQRT  = 5'd10;
  localparam logic [ST_W-1:0] S_SQRTW = 5'd11;
  localparam logic [ST_W-1:0] S_NDIV  = 5'd12;
  localparam logic [ST_W-1:0] S_NDIVW = 5'd13;
  localparam logic [ST_W-1:0] S_ENT   = 5'd14;
  localparam logic [ST_W-1:0] S_ENTW  = 5'd15;
  localparam logic [ST_W-1:0] S_CLAMP = 5'd16;
  localparam logic [ST_W-1:0] S_RMAC  = 5'd17;
  localparam logic [ST_W-1:0] S_RMACW = 5'd18;
  localparam logic [ST_W-1:0] S_DONE  = 5'd19;

  // Small coefficients applied to a shifted product
  localparam logic [2:0] C_P1 = 3'd0;
  localparam logic [2:0] C_M1 = 3'd1;
  localparam logic [2:0] C_P2 = 3'd2;
  localparam logic [2:0] C_M2 = 3'd3;
  localparam logic [2:0] C_P3 = 3'd4;
  localparam logic [2:0] C_M3 = 3'd5;

  localparam logic signed [ACC_W-1:0] ONE_Q   = ACC_W'(1) <<< QUAT_FRAC_BITS;
  localparam logic signed [ACC_W-1:0] ENT_LIM = (ACC_W'(1) <<< (QUAT_FRAC_BITS + 2)) - 1;
  localparam logic signed [ROW_W-1:0] SAT_MAX = ROW_W'(32'sh7FFF_FFFF);
  localparam logic signed [ROW_W-1:0] SAT_MIN = -ROW_W'(32'sh7FFF_FFFF) - 1;

  function automatic logic signed [ACC_W-1:0] scale(input logic signed [ACC_W-1:0] x,
                                                    input logic [2:0] c);
    logic signed [ACC_W-1:0] x3;
    x3 = x + (x <<< 1);
    case (c)
      C_P1:    return x;
      C_M1:    return -x;
      C_P2:    return x <<< 1;
      C_M2:    return -(x <<< 1);
      C_P3:    return x3;
      C_M3:    return -x3;
      default: return x;
    endcase
  endfunction

  logic [ST_W-1:0] state;

  // History and working registers
  logic signed [DATA_W-1:0] ql [4];
  logic signed [DATA_W-1:0] qb [4];
  logic signed [DATA_W-1:0] rl [3];
  logic signed [DATA_W-1:0] rb [3];
  logic signed [DATA_W-1:0] w  [3];
  logic        [STEP_W-1:0] step;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ROW_W-1:0]  acc2;
  logic        [MAG_W-1:0]  mag [4];
  logic                     neg [4];
  logic        [MAG_W-1:0]  maxm;
  logic        [SQ_ROOT_W-1:0] norm;
  logic signed [DATA_W-1:0] q0 [4];
  logic signed [ENT_W-1:0]  ent;
  logic signed [DATA_W-1:0] pr [3];
  logic signed [DATA_W-1:0] att [4];
  logic signed [DATA_W-1:0] plat [3];
  logic                     out_valid;

  // Sequencing counters
  logic [1:0] k;
  logic [1:0] j;
  logic       hsel;
  logic [1:0] r;
  logic [1:0] c;
  logic       tt;

  // Arithmetic units
  logic                   mul_start;
  logic signed [MA_W-1:0] mul_a;
  logic signed [MB_W-1:0] mul_b;
  logic signed [MP_W-1:0] mul_p;
  unit_stat_t             mul_st;
  logic                   div_start;
  logic [DIV_N_W-1:0]     div_num;
  logic [DIV_D_W-1:0]     div_den;
  logic [DIV_N_W-1:0]     div_q;
  unit_stat_t             div_st;
  logic                   sq_start;
  logic [SQ_ROOT_W-1:0]   sq_root;
  unit_stat_t             sq_st;

  qai_mul u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b), .st(mul_st), .p(mul_p)
  );

  qai_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .st(div_st), .quot(div_q)
  );

  qai_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .rad(acc[SQ_RAD_W-1:0]),
    .st(sq_st), .root(sq_root)
  );

  // Table lookups for the current step
  kin_term_t  kt;
  rot_entry_t re;
  logic [3:0] ent_idx;

  assign kt      = kin_term(k, j);
  assign ent_idx = 4'(r) * 4'd3 + 4'(c);
  assign re      = rot_entry(ent_idx);

  // Product views
  logic signed [ACC_W-1:0] pr_raw;
  logic signed [ACC_W-1:0] pr_rate;
  logic signed [ACC_W-1:0] pr_quat;

  assign pr_raw  = ACC_W'(mul_p);
  assign pr_rate = ACC_W'(mul_p >>> RATE_FRAC_BITS);
  assign pr_quat = ACC_W'(mul_p >>> QUAT_FRAC_BITS);

  // Update term and new unnormalized component
  logic [ACC_W-1:0]        acc_abs;
  logic signed [QN_W-1:0]  dq;
  logic signed [QN_W-1:0]  qsum;
  logic [MAG_W-1:0]        qsum_mag;
  logic signed [ACC_W-1:0] ent_raw;
  logic signed [ROW_W-1:0] row_sum;

  assign acc_abs  = acc[ACC_W-1] ? -acc : acc;
  assign dq       = acc[ACC_W-1] ? -$signed(div_q[QN_W-1:0]) : $signed(div_q[QN_W-1:0]);
  assign qsum     = QN_W'(ql[k]) + dq;
  assign qsum_mag = qsum[QN_W-1] ? MAG_W'(-qsum) : MAG_W'(qsum);
  assign ent_raw  = acc - (re.diag ? ONE_Q : '0);
  assign row_sum  = acc2 + ROW_W'(pr_quat);

  // Unit operand selection
  always_comb begin
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    sq_start  = 1'b0;
    case (state)
      S_KIN: begin
        mul_start = 1'b1;
        mul_a     = hsel ? MA_W'(rb[kt.wi]) : MA_W'(rl[kt.wi]);
        mul_b     = hsel ? MB_W'(qb[kt.qi]) : MB_W'(ql[kt.qi]);
      end
      S_STEP: begin
        mul_start = 1'b1;
        mul_a     = MA_W'(acc);
        mul_b     = $signed(MB_W'(step));
      end
      S_DDIV: begin
        div_start = 1'b1;
        div_num   = DIV_N_W'(acc_abs);
        div_den   = DIV_D_W'(DT_DIVISOR);
      end
      S_SQ: begin
        mul_start = 1'b1;
        mul_a     = $signed(MA_W'(mag[k]));
        mul_b     = $signed(MB_W'(mag[k]));
      end
      S_SQRT: begin
        sq_start = 1'b1;
      end
      S_NDIV: begin
        div_start = 1'b1;
        div_num   = (DIV_N_W'(mag[k]) << QUAT_FRAC_BITS) + DIV_N_W'(norm >> 1);
        div_den   = DIV_D_W'(norm);
      end
      S_ENT: begin
        mul_start = 1'b1;
        mul_a     = MA_W'(tt ? q0[re.i2] : q0[re.i1]);
        mul_b     = MB_W'(tt ? q0[re.j2] : q0[re.j1]);
      end
      S_RMAC: begin
        mul_start = 1'b1;
        mul_a     = MA_W'(ent);
        mul_b     = MB_W'(w[c]);
      end
      default: begin
      end
    endcase
  end

  logic sample_xfer;
  logic result_xfer;
  logic cfg_xfer;
  logic out_load;

  assign sample_xfer = sample.valid && sample.ready;
  assign result_xfer = result.valid && result.ready;
  assign cfg_xfer    = cfg.valid && cfg.ready;
  // Finished result moves into the output register
  assign out_load    = (state == S_DONE) && (!out_valid || result.ready);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      ql[0]     <= DATA_W'(ONE_Q);
      qb[0]     <= DATA_W'(ONE_Q);
      for (int i = 1; i < 4; i++) begin
        ql[i] <= '0;
        qb[i] <= '0;
      end
      for (int i = 0; i < 3; i++) begin
        rl[i] <= '0;
        rb[i] <= '0;
      end
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result_xfer) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (cfg_xfer) begin
            case (cfg.index)
              REG_INIT_QW: begin ql[0] <= cfg.data; qb[0] <= cfg.data; end
              REG_INIT_QX: begin ql[1] <= cfg.data; qb[1] <= cfg.data; end
              REG_INIT_QY: begin ql[2] <= cfg.data; qb[2] <= cfg.data; end
              REG_INIT_QZ: begin ql[3] <= cfg.data; qb[3] <= cfg.data; end
              default: begin
              end
            endcase
          end
          if (sample_xfer) begin
            w[0]  <= sample.rate_x;
            w[1]  <= sample.rate_y;
            w[2]  <= sample.rate_z;
            step  <= sample.step_time;
            k     <= '0;
            j     <= '0;
            hsel  <= 1'b0;
            acc   <= '0;
            maxm  <= '0;
            state <= S_KIN;
          end
        end

        // d = 3 * F(last) - F(before last), six products per component
        S_KIN: state <= S_KINW;
        S_KINW: begin
          if (mul_st.done) begin
            acc <= acc + scale(pr_rate, hsel ? (kt.neg ? C_P1 : C_M1)
                                             : (kt.neg ? C_M3 : C_P3));
            if (j == 2'd2) begin
              j <= '0;
              if (hsel) begin
                hsel  <= 1'b0;
                state <= S_STEP;
              end else begin
                hsel  <= 1'b1;
                state <= S_KIN;
              end
            end else begin
              j     <= j + 1'b1;
              state <= S_KIN;
            end
          end
        end

        // d * step, then truncating divide by the time scale
        S_STEP: state <= S_STEPW;
        S_STEPW: begin
          if (mul_st.done) begin
            acc   <= pr_raw;
            state <= S_DDIV;
          end
        end
        S_DDIV: state <= S_DDIVW;
        S_DDIVW: begin
          if (div_st.done) begin
            mag[k] <= qsum_mag;
            neg[k] <= qsum[QN_W-1];
            if (qsum_mag > maxm) begin
              maxm <= qsum_mag;
            end
            acc <= '0;
            if (k == 2'd3) begin
              state <= S_NSH;
            end else begin
              k     <= k + 1'b1;
              state <= S_KIN;
            end
          end
        end

        // Scale magnitudes so the largest lies in [2^30, 2^31); if all are zero, keep the last quaternion
        S_NSH: begin
          if (maxm == '0) begin
            for (int i = 0; i < 4; i++) begin
              q0[i] <= ql[i];
            end
            r     <= '0;
            c     <= '0;
            tt    <= 1'b0;
            acc2  <= '0;
            state <= S_ENT;
          end else if ((maxm >> 31) != '0) begin
            maxm <= maxm >> 1;
            for (int i = 0; i < 4; i++) begin
              mag[i] <= mag[i] >> 1;
            end
          end else if (!maxm[30]) begin
            maxm <= maxm << 1;
            for (int i = 0; i < 4; i++) begin
              mag[i] <= mag[i] << 1;
            end
          end else begin
            k     <= '0;
            state <= S_SQ;
          end
        end

        // Sum of squares and its floor square root
        S_SQ: state <= S_SQW;
        S_SQW: begin
          if (mul_st.done) begin
            acc <= acc + pr_raw;
            if (k == 2'd3) begin
              state <= S_SQRT;
            end else begin
              k     <= k + 1'b1;
              state <= S_SQ;
            end
          end
        end
        S_SQRT: state <= S_SQRTW;
        S_SQRTW: begin
          if (sq_st.done) begin
            norm  <= sq_root;
            k     <= '0;
            state <= S_NDIV;
          end
        end

        // Rounded division by the norm, sign restored
        S_NDIV: state <= S_NDIVW;
        S_NDIVW: begin
          if (div_st.done) begin
            q0[k] <= neg[k] ? -DATA_W'(div_q) : DATA_W'(div_q);
            if (k == 2'd3) begin
              r     <= '0;
              c     <= '0;
              tt    <= 1'b0;
              acc   <= '0;
              acc2  <= '0;
              state <= S_ENT;
            end else begin
              k     <= k + 1'b1;
              state <= S_NDIV;
            end
          end
        end

        // Rotation matrix entry from two quaternion products
        S_ENT: state <= S_ENTW;
        S_ENTW: begin
          if (mul_st.done) begin
            acc <= acc + scale(pr_quat, (tt && re.neg2) ? C_M2 : C_P2);
            if (tt) begin
              state <= S_CLAMP;
            end else begin
              tt    <= 1'b1;
              state <= S_ENT;
            end
          end
        end
        S_CLAMP: begin
          if (ent_raw > ENT_LIM) begin
            ent <= ENT_W'(ENT_LIM);
          end else if (ent_raw < -ENT_LIM) begin
            ent <= ENT_W'(-ENT_LIM);
          end else begin
            ent <= ENT_W'(ent_raw);
          end
          state <= S_RMAC;
        end

        // Row dot product with the body rate, saturated per row
        S_RMAC: state <= S_RMACW;
        S_RMACW: begin
          if (mul_st.done) begin
            acc  <= '0;
            tt   <= 1'b0;
            if (c == 2'd2) begin
              c    <= '0;
              acc2 <= '0;
              if (row_sum > SAT_MAX) begin
                pr[r] <= DATA_W'(SAT_MAX);
              end else if (row_sum < SAT_MIN) begin
                pr[r] <= DATA_W'(SAT_MIN);
              end else begin
                pr[r] <= DATA_W'(row_sum);
              end
              if (r == 2'd2) begin
                state <= S_DONE;
              end else begin
                r     <= r + 1'b1;
                state <= S_ENT;
              end
            end else begin
              acc2  <= row_sum;
              c     <= c + 1'b1;
              state <= S_ENT;
            end
          end
        end

        // Hand off the result and shift the histories
        S_DONE: begin
          if (out_load) begin
            for (int i = 0; i < 4; i++) begin
              att[i] <= q0[i];
              qb[i]  <= ql[i];
              ql[i]  <= q0[i];
            end
            for (int i = 0; i < 3; i++) begin
              plat[i] <= pr[i];
              rb[i]   <= rl[i];
              rl[i]   <= pr[i];
            end
            state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  assign sample.ready       = (state == S_IDLE);
  assign cfg.ready          = (state == S_IDLE);
  assign result.valid       = out_valid;
  assign result.att_w       = att[0];
  assign result.att_x       = att[1];
  assign result.att_y       = att[2];
  assign result.att_z       = att[3];
  assign result.plat_rate_x = plat[0];
  assign result.plat_rate_y = plat[1];
  assign result.plat_rate_z = plat[2];

  // The arithmetic units never overlap
  a_unit_exclusive: assert property (@(posedge clk) disable iff (rst)
    (mul_start || div_start || sq_start) |-> !mul_st.busy && !div_st.busy && !sq_st.busy)
    else $error("arithmetic unit started while another is busy");

  // An accepted sample starts the kinematic sums
  a_sample_starts: assert property (@(posedge clk) disable iff (rst)
    sample_xfer |=> state == S_KIN)
    else $error("accepted sample did not start the sequence");

  // Squares are taken only on normalized magnitudes
  a_norm_range: assert property (@(posedge clk) disable iff (rst)
    state == S_SQ |-> (maxm >> 31) == '0 && maxm[30])
    else $error("magnitudes not normalized before sum of squares");

  // A multiplier result arrives only while one of its wait states is active
  a_mul_done_wait: assert property (@(posedge clk) disable iff (rst)
    mul_st.done |-> state == S_KINW || state == S_STEPW || state == S_SQW ||
                    state == S_ENTW || state == S_RMACW)
    else $error("multiplier result with no consumer");

endmodule
